/* sv/lpd_pkg.sv */
// Package with the shared types and constants of the length-prefix deframer.
`default_nettype none

package lpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 32;

  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hFF;
  localparam logic [LEN_W-1:0]  ESC_GROUP2 = 32'h0000_FFFF;
  localparam logic [LEN_W-1:0]  ESC_GROUP3 = 32'h00FF_FFFF;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_GROUP2  = 3'd1,
    PH_GROUP3  = 3'd2,
    PH_GROUP4  = 3'd3,
    PH_PAYLOAD = 3'd4
  } lpd_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              end_of_frame;
    logic              empty_frame;
    logic [LEN_W-1:0]  frame_length;
  } lpd_result_t;

endpackage

`default_nettype wire

/* sv/length_prefix_deframer_unit.sv */
// Top level of the length-prefix deframer: input register, decoder and result register.
`default_nettype none

// The unit splits a byte stream into frames, each opened by an escaped length header
// (one byte below 255, or 255 followed by 2-, 3- and 4-byte big-endian groups while each
// group is all ones), and gives one output transaction per payload byte, flagging the last.
// A header that sums to zero gives a single empty-frame marker instead. It accepts one
// byte per clock cycle while the output is not stalled; each byte passes through the
// input register, then the combinational header decode and payload count, into the
// result register. Header bytes give no output transaction.

module length_prefix_deframer_unit (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [lpd_pkg::BYTE_W-1:0]  in_stream_byte,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [lpd_pkg::BYTE_W-1:0] out_payload_byte,
  output logic                       out_end_of_frame,
  output logic                       out_empty_frame,
  output logic [lpd_pkg::LEN_W-1:0]  out_frame_length
);

  import lpd_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              can_load;
  logic              fire;
  logic              in_take;
  logic              res_valid;
  lpd_result_t       result;

  assign fire         = s1_valid_r && can_load;
  assign in_stall     = s1_valid_r && !can_load;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take || (s1_valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_stream_byte;
    end
  end

  lpd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_in   (s1_byte_r),
    .res_valid (res_valid),
    .result    (result)
  );

  lpd_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (fire && res_valid),
    .result           (result),
    .out_stall        (out_stall),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_end_of_frame (out_end_of_frame),
    .out_empty_frame  (out_empty_frame),
    .out_frame_length (out_frame_length)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_frame |->
      out_end_of_frame && out_frame_length == '0 && out_payload_byte == '0)
    else $error("Malformed empty-frame marker.");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_frame |-> out_frame_length != '0)
    else $error("Payload transaction with zero frame length.");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid && out_stall |-> in_stall && !fire)
    else $error("Input taken while the result register is blocked.");
`endif

endmodule

`default_nettype wire

/* sv/lpd_step.sv */
// Header decoder and payload counter: the per-byte state update and result logic.
`default_nettype none

module lpd_step (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       fire,
  input  wire [lpd_pkg::BYTE_W-1:0] byte_in,
  output logic                      res_valid,
  output lpd_pkg::lpd_result_t      result
);

  import lpd_pkg::*;

  lpd_phase_t        phase_r, phase_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  group_r, group_nxt;
  logic [LEN_W-1:0]  sum_r, sum_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [LEN_W-1:0]  group_shift;
  logic [LEN_W-1:0]  group_sum;
  logic [LEN_W-1:0]  hdr_len;
  logic              hdr_done;

  assign group_shift = {group_r[LEN_W-BYTE_W-1:0], byte_in};
  assign group_sum   = sum_r + group_shift;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    group_nxt = group_r;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    hdr_done  = 1'b0;
    hdr_len   = group_sum;
    res_valid = 1'b0;
    result    = '0;
    unique case (phase_r)
      PH_PAYLOAD: begin
        res_valid           = 1'b1;
        result.payload_byte = byte_in;
        result.end_of_frame = (left_r == LEN_W'(1));
        result.frame_length = sum_r;
        left_nxt            = left_r - LEN_W'(1);
        if (left_r == LEN_W'(1)) begin
          phase_nxt = PH_FIRST;
          sum_nxt   = '0;
        end
      end
      PH_GROUP2, PH_GROUP3, PH_GROUP4: begin
        if (cnt_r != phase_r[1:0]) begin
          cnt_nxt   = cnt_r + 2'd1;
          group_nxt = group_shift;
        end else begin
          sum_nxt   = group_sum;
          cnt_nxt   = '0;
          group_nxt = '0;
          if (phase_r == PH_GROUP2 && group_shift == ESC_GROUP2) begin
            phase_nxt = PH_GROUP3;
          end else if (phase_r == PH_GROUP3 && group_shift == ESC_GROUP3) begin
            phase_nxt = PH_GROUP4;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      default: begin
        sum_nxt   = {{(LEN_W-BYTE_W){1'b0}}, byte_in};
        hdr_len   = {{(LEN_W-BYTE_W){1'b0}}, byte_in};
        cnt_nxt   = '0;
        group_nxt = '0;
        if (byte_in == ESC_BYTE) begin
          phase_nxt = PH_GROUP2;
        end else begin
          hdr_done = 1'b1;
        end
      end
    endcase
    if (hdr_done) begin
      left_nxt = hdr_len;
      if (hdr_len == '0) begin
        phase_nxt           = PH_FIRST;
        res_valid           = 1'b1;
        result.end_of_frame = 1'b1;
        result.empty_frame  = 1'b1;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      cnt_r   <= '0;
      group_r <= '0;
      sum_r   <= '0;
      left_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      group_r <= group_nxt;
      sum_r   <= sum_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/lpd_out_reg.sv */
// Result register that holds one transaction on the output channel.
`default_nettype none

module lpd_out_reg (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        load,
  input  lpd_pkg::lpd_result_t       result,
  input  wire                        out_stall,
  output logic                       can_load,
  output logic                       out_valid,
  output logic [lpd_pkg::BYTE_W-1:0] out_payload_byte,
  output logic                       out_end_of_frame,
  output logic                       out_empty_frame,
  output logic [lpd_pkg::LEN_W-1:0]  out_frame_length
);

  import lpd_pkg::*;

  logic        valid_r, valid_nxt;
  lpd_result_t data_r;

  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = can_load ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid        = valid_r;
  assign out_payload_byte = data_r.payload_byte;
  assign out_end_of_frame = data_r.end_of_frame;
  assign out_empty_frame  = data_r.empty_frame;
  assign out_frame_length = data_r.frame_length;

endmodule

`default_nettype wire
